// ===== sv/poc_pkg.sv =====
// poc_pkg: shared types and constants of the pattern occurrence remover
// item and result transaction structs, command codes, cell control struct
// no dependencies
package poc_pkg;

  localparam int DEF_MAX_PATTERN = 16;
  localparam int VALUE_W = 32;
  localparam int LEN_W = 5;
  localparam int INDEX_W = 4;

  typedef enum logic {
    CMD_PATTERN  = 1'b0,
    CMD_SEQUENCE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                      command;
    logic [INDEX_W-1:0]        pattern_index;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] kept_value;
    logic                      has_value;
    logic                      end_of_sequence;
  } result_t;

  typedef struct packed {
    logic pat_we;
    logic app_here;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/poc_cell.sv =====
// poc_cell: one window position of the remover chain
// holds one pattern element and one pending element, compares the two
// depends on poc_pkg
module poc_cell import poc_pkg::*; (
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic signed [VALUE_W-1:0] data,
  input  logic signed [VALUE_W-1:0] next_value,
  output logic signed [VALUE_W-1:0] value,
  output logic                      match
);

  logic signed [VALUE_W-1:0] pat;
  logic signed [VALUE_W-1:0] win;

  // pending element as seen this cycle, including an element appended here
  assign value = ctrl.app_here ? data : win;
  assign match = (value == pat);

  always_ff @(posedge clk) begin
    if (ctrl.pat_we) begin
      pat <= data;
    end
    if (ctrl.shift) begin
      win <= next_value;
    end else if (ctrl.app_here) begin
      win <= data;
    end
  end

endmodule

// ===== sv/poc_outq.sv =====
// poc_outq: two-entry result queue between the chain control and the receiver
// lets the chain keep taking transactions while one result waits
// depends on poc_pkg
module poc_outq import poc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    valid,
  input  logic    stall,
  output result_t data
);

  result_t    e0;
  result_t    e1;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       pop;

  assign pop   = valid && !stall;
  assign valid = (cnt != 2'd0);
  assign full  = (cnt == 2'd2);
  assign data  = e0;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e0 <= (cnt == 2'd2) ? e1 : push_data;
      e1 <= push_data;
    end else if (push) begin
      if (cnt == 2'd0) begin
        e0 <= push_data;
      end else begin
        e1 <= push_data;
      end
    end
  end

endmodule

// ===== sv/pattern_occurrence_remover.sv =====
// pattern_occurrence_remover: top level, chain of window cells and step control
// depends on poc_pkg, poc_cell, poc_outq
//
// Usage: write pattern_length on the cfg channel (cfg_ready is always high),
// then write pattern elements with item transactions of command CMD_PATTERN.
// Sequence elements follow as item transactions of command CMD_SEQUENCE, the
// final one with last set. Each result transaction carries one kept element,
// or on a sequence end with nothing left a bare end marker (has_value 0).
// Throughput: one item per cycle while item_stall is low; a kept element is
// pushed into the registered result queue by the item that releases it. The
// window chain does one step per cycle while the result queue is not full;
// an item that ends a sequence holds its last kept element back until the
// window is empty, emitting each remaining window element and then the end
// mark. After a length change mid-sequence the old window is reworked from
// the next sequence element on, one step per cycle with item_stall high.
// A match on a window longer than the pattern drops one element a cycle while the result queue is not full.
// Reset clears the window, the length register and any pending end; pattern
// elements are undefined until written. When result_stall is high the two-entry
// result queue fills and item_stall then rises; nothing is lost.
module pattern_occurrence_remover import poc_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEN_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [LEN_W-1:0]          pattern_length;
  logic [CNT_W-1:0]          len;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [CNT_W-1:0]          drop_left;
  logic [CNT_W-1:0]          drop_left_next;
  logic                      flush;
  logic                      flush_next;
  logic                      hold_valid;
  logic                      hold_valid_next;
  logic signed [VALUE_W-1:0] hold_value;
  logic signed [VALUE_W-1:0] hold_value_next;
  logic                      armed;
  logic                      armed_next;

  logic                      full;
  logic                      busy;
  logic                      work;
  logic                      acc;
  logic                      seq;
  logic                      pw;
  logic [CNT_W-1:0]          vc;
  logic                      vf;
  logic                      win_match;
  logic                      emit;
  logic                      shift;
  logic                      push;
  result_t                   push_data;

  logic signed [VALUE_W-1:0] v [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]    eq;
  logic [MAX_PATTERN-1:0]    mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pattern_length <= cfg_data;
    end
  end

  assign len = (CMP_W'(pattern_length) > CMP_W'(MAX_PATTERN)) ?
               CNT_W'(MAX_PATTERN) : CNT_W'(pattern_length);

  // window still holds work for the current length
  assign work = (len == '0) ? (count != '0) : (count >= len);
  assign busy = (drop_left != '0) || flush || (armed && work);
  assign item_stall = busy || full;
  assign acc = item_valid && !item_stall;
  assign seq = acc && (item.command == CMD_SEQUENCE);
  assign pw  = acc && (item.command == CMD_PATTERN);
  assign vc  = count + CNT_W'(seq);
  assign vf  = flush || (seq && item.last);
  assign armed_next = seq || (armed && work);

  genvar i;
  generate
    for (i = 0; i < MAX_PATTERN; i++) begin : g_cell
      cell_ctrl_t                ctrl;
      logic signed [VALUE_W-1:0] nxt;

      assign ctrl.pat_we   = pw && (32'(item.pattern_index) == i);
      assign ctrl.app_here = seq && (count == CNT_W'(i));
      assign ctrl.shift    = shift;
      assign mask[i]       = (CNT_W'(i) < len);

      if (i < MAX_PATTERN - 1) begin : g_mid
        assign nxt = v[i+1];
      end else begin : g_end
        assign nxt = '0;
      end

      poc_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .data       (item.value),
        .next_value (nxt),
        .value      (v[i]),
        .match      (eq[i])
      );
    end
  endgenerate

  assign win_match = &(eq | ~mask);
  assign emit = ((len == '0) && (vc != '0)) ||
                ((len != '0) && (vc >= len) && !win_match) ||
                ((len != '0) && (vc < len) && vf && (vc != '0));

  always_comb begin
    count_next      = count;
    drop_left_next  = drop_left;
    flush_next      = flush;
    hold_valid_next = hold_valid;
    hold_value_next = hold_value;
    shift           = 1'b0;
    push            = 1'b0;
    push_data       = '0;
    if (!full && (seq || busy)) begin
      priority if (drop_left != '0) begin
        shift          = 1'b1;
        count_next     = vc - CNT_W'(1);
        drop_left_next = drop_left - CNT_W'(1);
      end else if (emit) begin
        shift      = 1'b1;
        count_next = vc - CNT_W'(1);
        flush_next = vf;
        if (vf) begin
          hold_valid_next = 1'b1;
          hold_value_next = v[0];
          if (hold_valid) begin
            push      = 1'b1;
            push_data = '{kept_value: hold_value, has_value: 1'b1, end_of_sequence: 1'b0};
          end
        end else begin
          push      = 1'b1;
          push_data = '{kept_value: v[0], has_value: 1'b1, end_of_sequence: 1'b0};
        end
      end else if ((len != '0) && (vc >= len)) begin
        flush_next = vf;
        if (vc == len) begin
          count_next = '0;
        end else begin
          shift          = 1'b1;
          count_next     = vc - CNT_W'(1);
          drop_left_next = len - CNT_W'(1);
        end
      end else if (vf && (vc == '0)) begin
        push            = 1'b1;
        push_data       = '{kept_value: hold_valid ? hold_value : '0,
                            has_value: hold_valid, end_of_sequence: 1'b1};
        hold_valid_next = 1'b0;
        flush_next      = 1'b0;
        count_next      = vc;
      end else begin
        count_next = vc;
        flush_next = vf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      drop_left  <= '0;
      flush      <= 1'b0;
      hold_valid <= 1'b0;
      armed      <= 1'b0;
    end else begin
      count      <= count_next;
      drop_left  <= drop_left_next;
      flush      <= flush_next;
      hold_valid <= hold_valid_next;
      armed      <= armed_next;
    end
  end

  always_ff @(posedge clk) begin
    hold_value <= hold_value_next;
  end

  poc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .valid     (result_valid),
    .stall     (result_stall),
    .data      (result)
  );

endmodule

// ===== dv/pattern_occurrence_remover_checker.sv =====
`timescale 1ns / 100ps
// pattern_occurrence_remover_checker: watches the item, result and cfg channels, predicts
// the surviving elements of each sequence and compares every result transaction
// depends on poc_pkg
module pattern_occurrence_remover_checker import poc_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  item_t            item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  result_t          result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             run_done,
  output int               mismatches,
  output int               outstanding
);

  logic signed [VALUE_W-1:0] pattern_mem [MAX_PATTERN];
  logic signed [VALUE_W-1:0] window_q [$];
  logic [LEN_W-1:0]          length_reg;
  result_t                   kept_q [$];
  int n_elements, n_writes, n_results, n_markers, n_dropped, n_lengths;
  bit summary_done;

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic bit window_matches(input int span);
    for (int i = 0; i < span; i++)
      if (window_q[i] !== pattern_mem[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic keep_oldest();
    result_t r;
    r.kept_value = window_q.pop_front();
    r.has_value = 1'b1;
    r.end_of_sequence = 1'b0;
    kept_q.insert(kept_q.size(), r);
  endtask

  task automatic advance_window(input item_t it);
    int span;
    int emitted;
    result_t r;
    span = (length_reg > MAX_PATTERN) ? MAX_PATTERN : int'(length_reg);
    if (it.command == CMD_PATTERN) begin
      n_writes++;
      if (it.pattern_index < MAX_PATTERN) pattern_mem[it.pattern_index] = it.value;
      return;
    end
    n_elements++;
    emitted = 0;
    window_q.insert(window_q.size(), it.value);
    // an empty pattern lets every element straight through
    while (window_q.size() > 0 && window_q.size() >= span) begin
      if (span > 0 && window_matches(span)) begin
        for (int i = 0; i < span; i++) r.kept_value = window_q.pop_front();
        n_dropped++;
      end else begin
        keep_oldest();
        emitted++;
      end
    end
    if (it.last) begin
      while (window_q.size() > 0) begin
        keep_oldest();
        emitted++;
      end
      if (emitted > 0) begin
        r = kept_q.pop_back();
        r.end_of_sequence = 1'b1;
        kept_q.insert(kept_q.size(), r);
      end else begin
        // nothing left to emit: bare end marker
        r.kept_value = '0;
        r.has_value = 1'b0;
        r.end_of_sequence = 1'b1;
        kept_q.insert(kept_q.size(), r);
        n_markers++;
      end
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    n_results++;
    if (kept_q.size() == 0) begin
      report($sformatf("result transaction %0d/%0b/%0b with nothing expected",
                       got.kept_value, got.has_value, got.end_of_sequence));
      return;
    end
    want = kept_q.pop_front();
    if (got.kept_value !== want.kept_value)
      report($sformatf("kept_value %0d, expected %0d", got.kept_value, want.kept_value));
    if (got.has_value !== want.has_value)
      report($sformatf("has_value %b, expected %b", got.has_value, want.has_value));
    if (got.end_of_sequence !== want.end_of_sequence)
      report($sformatf("end_of_sequence %b, expected %b (kept_value %0d)",
                       got.end_of_sequence, want.end_of_sequence, want.kept_value));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      window_q.delete();
      kept_q.delete();
      length_reg = '0;
      mismatches = 0;
      outstanding <= 0;
      n_elements = 0;
      n_writes = 0;
      n_results = 0;
      n_markers = 0;
      n_dropped = 0;
      n_lengths = 0;
      summary_done = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        length_reg = cfg_data;
        n_lengths++;
      end
      if (item_valid && !item_stall) advance_window(item);
      if (result_valid && !result_stall) check_result(result);
      if (run_done && !summary_done) begin
        summary_done = 1'b1;
        $display("covered %0d sequence elements and %0d pattern writes over %0d length settings",
                 n_elements, n_writes, n_lengths);
        $display("checked %0d results: %0d bare end markers, %0d occurrences removed",
                 n_results, n_markers, n_dropped);
        if (kept_q.size() > 0)
          report($sformatf("%0d expected results never arrived", kept_q.size()));
      end
      outstanding <= kept_q.size();
    end
  end

endmodule

// ===== dv/pattern_occurrence_remover_tb.sv =====
`timescale 1ns / 100ps
// pattern_occurrence_remover_tb: clock, reset and stimulus for the pattern occurrence remover,
// a directed part then random phases of bursty items against a stalling receiver
// depends on poc_pkg, pattern_occurrence_remover, pattern_occurrence_remover_checker
module pattern_occurrence_remover_tb;
  import poc_pkg::*;

  localparam int MAX_PATTERN = DEF_MAX_PATTERN;
  localparam int RANDOM_ITEMS = 220;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT = 2000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid;
  logic             item_stall;
  item_t            item;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data;
  logic             run_done;
  int               mismatches;
  int               outstanding;

  logic signed [VALUE_W-1:0] pattern_copy [MAX_PATTERN];
  logic signed [VALUE_W-1:0] alpha_base = '0;
  int burst_left = 0;
  int items_sent = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_period = 1;
  int stall_duty = 0;
  int stall_tick = 0;
  int stall_mode_left = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  pattern_occurrence_remover #(.MAX_PATTERN(MAX_PATTERN)) dut (.*);

  pattern_occurrence_remover_checker #(.MAX_PATTERN(MAX_PATTERN)) removal_check (.*);

  // receiver: randomly changing stall pattern, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode_left = $urandom_range(10, 60);
        stall_period = $urandom_range(1, 6);
        stall_duty = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period - 1);
        stall_tick = 0;
      end
      stall_mode_left--;
      result_stall <= (stall_tick % stall_period) < stall_duty;
      stall_tick++;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val, input logic lst);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    item_valid <= 1'b1;
    item <= '{command: cmd, pattern_index: idx, value: val, last: lst};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_element(input logic signed [VALUE_W-1:0] val, input logic lst);
    send_item(CMD_SEQUENCE, INDEX_W'($urandom_range(0, MAX_PATTERN - 1)), val, lst);
  endtask

  task automatic load_entry(input int idx, input logic signed [VALUE_W-1:0] val);
    pattern_copy[idx] = val;
    send_item(CMD_PATTERN, INDEX_W'(idx), val, 1'($urandom_range(0, 1)));
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // a pattern write or a partial window gives no result but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return alpha_base + $urandom_range(0, 2);
  endfunction

  initial begin
    int span;
    int n_seq;
    int target;
    int k;
    int pick;
    int phase;
    bit kept_window;
    bit hold_now;
    bit end_open;
    logic [LEN_W-1:0] len;
    logic signed [VALUE_W-1:0] elems [$];
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    run_done <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty pattern, value extremes pass straight through
    write_length('0);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'h7fff_ffff, 1'b0);
    send_element('0, 1'b1);
    // every entry written once so no compare reads an unwritten one
    for (int i = 0; i < MAX_PATTERN; i++)
      load_entry(i, (i == 0) ? 32'h7fff_ffff : (i == 1) ? 32'h8000_0000 : $urandom);
    // whole sequence is one occurrence
    write_length(5'd2);
    send_element(32'h7fff_ffff, 1'b0);
    send_element(32'h8000_0000, 1'b1);
    // length beyond the store size
    write_length(5'd31);
    send_element(32'h0000_0001, 1'b0);
    send_element(32'hffff_ffff, 1'b1);
    // length change with a partly filled window
    write_length(5'd3);
    send_element(32'h7fff_ffff, 1'b0);
    write_length(5'd1);
    send_element(32'h8000_0000, 1'b1);

    phase = 0;
    kept_window = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) len = '0;
      else if (pick == 1) len = 5'd16;
      else if (pick == 2) len = LEN_W'($urandom_range(17, 31));
      else if (pick == 3) len = LEN_W'($urandom_range(5, 15));
      else len = LEN_W'($urandom_range(1, 4));
      write_length(len);
      span = (len > MAX_PATTERN) ? MAX_PATTERN : int'(len);
      // a window left open keeps its pattern so the rework is against known entries
      if (!kept_window) begin
        case ($urandom_range(0, 3))
          0: alpha_base = 32'h7fff_fffe;
          1: alpha_base = 32'h8000_0000;
          default: alpha_base = $urandom;
        endcase
        for (int i = 0; i < span; i++) load_entry(i, pick_value());
      end
      hold_now = (phase == 1) || ($urandom_range(0, 11) == 0);
      n_seq = $urandom_range(1, 3);
      kept_window = 1'b0;
      for (int s = 0; s < n_seq; s++) begin
        elems.delete();
        target = (hold_now && s == 0) ? 40 : $urandom_range(1, 20);
        while (elems.size() < target) begin
          pick = $urandom_range(0, 9);
          if (span > 0 && pick < 4) k = span;
          else if (span > 1 && pick < 6) k = $urandom_range(1, span - 1);
          else k = 0;
          if (k == 0) elems.insert(elems.size(), pick_value());
          else for (int j = 0; j < k; j++) elems.insert(elems.size(), pattern_copy[j]);
        end
        end_open = (s == n_seq - 1) && ($urandom_range(0, 4) == 0);
        if (hold_now && s == 0) hold_requests++;
        foreach (elems[j]) begin
          if ($urandom_range(0, 29) == 0)
            load_entry($urandom_range(0, MAX_PATTERN - 1), pick_value());
          send_element(elems[j], (j == elems.size() - 1) && !end_open);
        end
        kept_window = end_open;
      end
      phase++;
    end

    drain_results();
    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
